/* hdl/double_hash_table_core_defines.svh */
// Assertion macros used by the checker file of the hash table core.
`ifndef DOUBLE_HASH_TABLE_CORE_DEFINES_SVH
`define DOUBLE_HASH_TABLE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DHT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/dht_pkg.sv */
// Package with types and constants of the hash table core.
package dht_pkg;

  // Table geometry.
  localparam int TABLE_SIZE = 1021;
  localparam int STEP_MOD   = TABLE_SIZE - 2;
  localparam int SLOT_W     = $clog2(TABLE_SIZE);

  // Table size widened by one bit so that a power-of-two size still fits.
  localparam logic [SLOT_W:0] TS_M   = (SLOT_W+1)'(TABLE_SIZE);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);

  // Field widths.
  localparam int OP_W     = 2;
  localparam int KEY_W    = 31;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_ST_W = 2;

  // Remainders by reciprocal multiplication. With l = ceil(log2 d) and
  // RCP = ceil(2^(KEY_W+l) / d), (key * RCP) >> (KEY_W+l) is the exact
  // quotient key / d for every key, and RCP fits in KEY_W+1 bits.
  localparam int RCP_W      = KEY_W + 1;
  localparam int PROD_W     = KEY_W + RCP_W;
  localparam int TS_SHIFT   = KEY_W + $clog2(TABLE_SIZE);
  localparam int STEP_SHIFT = KEY_W + $clog2(STEP_MOD);
  localparam logic [RCP_W-1:0] TS_RCP =
    RCP_W'(((64'd1 << TS_SHIFT) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE));
  localparam logic [RCP_W-1:0] STEP_RCP =
    RCP_W'(((64'd1 << STEP_SHIFT) + 64'(STEP_MOD - 1)) / 64'(STEP_MOD));
  localparam logic [KEY_W-1:0] TS_DIV   = KEY_W'(TABLE_SIZE);
  localparam logic [KEY_W-1:0] STEP_DIV = KEY_W'(STEP_MOD);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // Result codes.
  localparam logic [STATUS_W-1:0] RES_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] RES_UPDATED   = 3'd1;
  localparam logic [STATUS_W-1:0] RES_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] RES_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] RES_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] RES_REMOVED   = 3'd5;

  // Slot states.
  localparam logic [SLOT_ST_W-1:0] ST_EMPTY   = 2'd0;
  localparam logic [SLOT_ST_W-1:0] ST_USED    = 2'd1;
  localparam logic [SLOT_ST_W-1:0] ST_DELETED = 2'd2;

  // Request and result payloads.
  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] found_value;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;
    logic load;
    logic hash;
    logic eval;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic finish;
  } stat_t;

endpackage

/* hdl/dht_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hdl/dht_ctrl.sv */
// Controller state machine of the hash table core.
module dht_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dht_pkg::stat_t    stat,
  output dht_pkg::cmd_t     cmd,
  output logic              busy
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_READ  = 5'b01000,
    S_EVAL  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // State register; reset starts the clearing pass over the slot states.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.finish) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_READ;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

/* hdl/dht_dpath.sv */
// Datapath of the hash table core: hashing, probe address, slot stores, result.
module dht_dpath (
  input  logic           clk,
  input  logic           rst,
  input  dht_pkg::cmd_t  cmd,
  input  dht_pkg::req_t  request,
  output dht_pkg::stat_t stat,
  output logic           done,
  output dht_pkg::res_t  result
);

  // Captured request.
  logic [dht_pkg::OP_W-1:0]         op_q;
  logic [dht_pkg::KEY_W-1:0]        key_q;
  logic signed [dht_pkg::VAL_W-1:0] val_q;

  // Reciprocal products of the key and the remainders derived from them.
  logic [dht_pkg::PROD_W-1:0] prod_ts;
  logic [dht_pkg::PROD_W-1:0] prod_step;
  logic [dht_pkg::KEY_W-1:0]  quo_ts;
  logic [dht_pkg::KEY_W-1:0]  quo_step;
  logic [dht_pkg::KEY_W-1:0]  rem_ts;
  logic [dht_pkg::KEY_W-1:0]  rem_step;

  // Probe state.
  logic [dht_pkg::SLOT_W-1:0] pos;
  logic [dht_pkg::SLOT_W-1:0] step;
  logic [dht_pkg::SLOT_W-1:0] cnt;
  logic [dht_pkg::SLOT_W-1:0] pos_adv;
  logic [dht_pkg::SLOT_W:0]   pos_sum;

  // Store read data.
  logic [dht_pkg::SLOT_ST_W-1:0]    rd_st;
  logic [dht_pkg::KEY_W-1:0]        rd_key;
  logic signed [dht_pkg::VAL_W-1:0] rd_val;

  // Decision of one probe.
  logic                             finish;
  logic [dht_pkg::STATUS_W-1:0]     res_code;
  logic signed [dht_pkg::VAL_W-1:0] res_fv;
  logic                             st_we;
  logic [dht_pkg::SLOT_ST_W-1:0]    st_wd;
  logic                             key_we;
  logic                             val_we;
  logic                             key_eq;
  logic                             last_probe;

  // Store write ports.
  logic                          st_ram_we;
  logic [dht_pkg::SLOT_ST_W-1:0] st_ram_wd;

  // Key modulo the table size and modulo the step modulus.
  assign quo_ts   = dht_pkg::KEY_W'(prod_ts >> dht_pkg::TS_SHIFT);
  assign quo_step = dht_pkg::KEY_W'(prod_step >> dht_pkg::STEP_SHIFT);
  assign rem_ts   = key_q - quo_ts * dht_pkg::TS_DIV;
  assign rem_step = key_q - quo_step * dht_pkg::STEP_DIV;

  // Next probe slot; pos and step both stay below the table size.
  assign pos_sum = {1'b0, pos} + {1'b0, step};
  assign pos_adv = (pos_sum >= dht_pkg::TS_M) ? dht_pkg::SLOT_W'(pos_sum - dht_pkg::TS_M)
                                              : dht_pkg::SLOT_W'(pos_sum);

  // Request capture and reciprocal products.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= request.operation;
      key_q     <= request.key;
      val_q     <= request.value;
      prod_ts   <= dht_pkg::PROD_W'(request.key) * dht_pkg::PROD_W'(dht_pkg::TS_RCP);
      prod_step <= dht_pkg::PROD_W'(request.key) * dht_pkg::PROD_W'(dht_pkg::STEP_RCP);
    end
  end

  // Probe position doubles as the address counter of the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (cmd.clr) begin
      pos <= pos + 1'b1;
    end else if (cmd.hash) begin
      pos <= dht_pkg::SLOT_W'(rem_ts);
    end else if (cmd.eval && !finish) begin
      pos <= pos_adv;
    end
  end

  // Probe step and probe count.
  always_ff @(posedge clk) begin
    if (cmd.hash) begin
      step <= dht_pkg::SLOT_W'(rem_step) + 1'b1;
    end
    if (cmd.load) begin
      cnt <= '0;
    end else if (cmd.eval && !finish) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Slot stores, all read at the current probe slot.
  assign st_ram_we = cmd.clr || (cmd.eval && st_we);
  assign st_ram_wd = cmd.clr ? dht_pkg::ST_EMPTY : st_wd;

  dht_ram #(.WIDTH(dht_pkg::SLOT_ST_W), .DEPTH(dht_pkg::TABLE_SIZE)) u_status_ram (
    .clk   (clk),
    .we    (st_ram_we),
    .waddr (pos),
    .wdata (st_ram_wd),
    .raddr (pos),
    .rdata (rd_st)
  );

  dht_ram #(.WIDTH(dht_pkg::KEY_W), .DEPTH(dht_pkg::TABLE_SIZE)) u_key_ram (
    .clk   (clk),
    .we    (cmd.eval && key_we),
    .waddr (pos),
    .wdata (key_q),
    .raddr (pos),
    .rdata (rd_key)
  );

  dht_ram #(.WIDTH(dht_pkg::VAL_W), .DEPTH(dht_pkg::TABLE_SIZE)) u_value_ram (
    .clk   (clk),
    .we    (cmd.eval && val_we),
    .waddr (pos),
    .wdata (val_q),
    .raddr (pos),
    .rdata (rd_val)
  );

  // Evaluate one probed slot against the pending request.
  assign key_eq     = (rd_st == dht_pkg::ST_USED) && (rd_key == key_q);
  assign last_probe = (cnt == dht_pkg::LAST_SLOT);

  always_comb begin
    finish   = 1'b0;
    res_code = dht_pkg::RES_NOT_FOUND;
    res_fv   = '0;
    st_we    = 1'b0;
    st_wd    = dht_pkg::ST_USED;
    key_we   = 1'b0;
    val_we   = 1'b0;
    case (op_q) inside
      dht_pkg::OP_INSERT: begin
        if (rd_st == dht_pkg::ST_EMPTY || rd_st == dht_pkg::ST_DELETED) begin
          finish   = 1'b1;
          res_code = dht_pkg::RES_INSERTED;
          st_we    = 1'b1;
          key_we   = 1'b1;
          val_we   = 1'b1;
        end else if (key_eq) begin
          finish   = 1'b1;
          res_code = dht_pkg::RES_UPDATED;
          val_we   = 1'b1;
        end else if (last_probe) begin
          finish   = 1'b1;
          res_code = dht_pkg::RES_FULL;
        end
      end
      dht_pkg::OP_FIND, dht_pkg::OP_REMOVE: begin
        if (rd_st == dht_pkg::ST_EMPTY) begin
          finish = 1'b1;
        end else if (key_eq) begin
          finish = 1'b1;
          if (op_q == dht_pkg::OP_FIND) begin
            res_code = dht_pkg::RES_FOUND;
            res_fv   = rd_val;
          end else begin
            res_code = dht_pkg::RES_REMOVED;
            st_we    = 1'b1;
            st_wd    = dht_pkg::ST_DELETED;
          end
        end else if (last_probe) begin
          finish = 1'b1;
        end
      end
      default: begin
        // The unused operation code answers not found at once.
        finish = 1'b1;
      end
    endcase
  end

  // Status toward the controller.
  assign stat.clr_last = (pos == dht_pkg::LAST_SLOT);
  assign stat.finish   = finish;

  // Result register and its one-cycle strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.eval && finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && finish) begin
      result.status      <= res_code;
      result.found_value <= res_fv;
    end
  end

endmodule

/* hdl/double_hash_table_core.sv */
// Top level of the double-hashing key/value table core.
//
// A request (insert, find or remove of a key, with a value for insert) is
// taken at a rising edge where start is high and busy is low. Exactly one
// result per request follows: status and found_value are valid for the single
// cycle in which done is high. The receiver cannot stall the result.
//
// After reset the core sweeps the slot state store to empty, one slot per
// cycle, over all TABLE_SIZE slots (1021 here); busy stays high meanwhile.
//
// At the request edge the key is multiplied by fixed reciprocals; the hash
// state then turns the products into the start slot and the probe step.
// Slots are then probed one at a time, each probe a store read followed by
// its evaluation. The result strobe comes after p probes and busy drops in
// that same cycle, so a new request is taken only once the last result is
// out. p runs from 1 up to TABLE_SIZE for a full table.
module double_hash_table_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  dht_pkg::req_t request,
  output logic          done,
  output dht_pkg::res_t result
);

  dht_pkg::cmd_t  cmd;
  dht_pkg::stat_t stat;

  // Sequencer.
  dht_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hashing, slot stores and result.
  dht_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .stat    (stat),
    .done    (done),
    .result  (result)
  );

endmodule

/* hdl/dht_chk.sv */
// Port-level checker of the hash table core and its bind statement.
`include "double_hash_table_core_defines.svh"

module dht_chk (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input dht_pkg::req_t request,
  input logic          done,
  input dht_pkg::res_t result
);

  // A result appears only once the core is ready for the next request.
  `DHT_ASSERT_SAME(a_done_not_busy, done, !busy, "result strobe while busy")

  // An accepted request keeps the core busy in the following cycle.
  `DHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy low after request")

  // A single strobe per request: results never arrive in adjacent cycles.
  `DHT_ASSERT_NEXT(a_single_strobe, done, !done, "result strobe held two cycles")

  // Only a successful find carries a value.
  `DHT_ASSERT_SAME(a_value_zero, done && result.status != dht_pkg::RES_FOUND,
                   result.found_value == 0, "value returned without a find hit")

endmodule

bind double_hash_table_core dht_chk u_chk (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);
